[sv/rbfh_pkg.sv]
package rbfh_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 32;
    localparam int DIR_W         = 32;
    // Magnitude of plane minus origin needs one bit more than a coordinate.
    localparam int MAG_W         = COORD_W + 1;
    localparam int NUM_FACES     = 6;
    localparam int FACE_W        = 3;

    localparam logic [FACE_W-1:0] FACE_PZ   = 3'd0;
    localparam logic [FACE_W-1:0] FACE_PY   = 3'd1;
    localparam logic [FACE_W-1:0] FACE_PX   = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NZ   = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NY   = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NX   = 3'd5;
    localparam logic [FACE_W-1:0] FACE_NONE = 3'd6;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t [2:0] o;
        coord_t [2:0] d;
        coord_t [2:0] lo;
        coord_t [2:0] hi;
    } item_t;

    // Faces run +z, +y, +x, -z, -y, -x.
    function automatic int face_axis(input int face);
        int axis;
        case (face)
            0, 3:    axis = 2;
            1, 4:    axis = 1;
            default: axis = 0;
        endcase
        return axis;
    endfunction

endpackage

[sv/rbfh_div.sv]
module rbfh_div #(
    parameter int FRAC_BITS = rbfh_pkg::FRAC_BITS_DEF
) (
    input  logic                                     clk,
    input  logic [rbfh_pkg::MAG_W+FRAC_BITS-1:0]     dividend,
    input  logic [rbfh_pkg::DIR_W-1:0]               divisor,
    output logic [rbfh_pkg::MAG_W+FRAC_BITS-1:0]     quotient
);
    import rbfh_pkg::*;

    localparam int QW = MAG_W + FRAC_BITS;

    logic [QW-1:0]    dvd_reg [QW];
    logic [QW-1:0]    quo_reg [QW];
    logic [DIR_W-1:0] rem_reg [QW];
    logic [DIR_W-1:0] dvs_reg [QW];

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [QW-1:0]    dvd_in;
        logic [QW-1:0]    quo_in;
        logic [DIR_W-1:0] rem_in;
        logic [DIR_W-1:0] dvs_in;
        logic [DIR_W:0]   trial;
        logic [DIR_W:0]   diff;
        logic             ge;

        if (s == 0) begin : g_first
            assign dvd_in = dividend;
            assign quo_in = '0;
            assign rem_in = '0;
            assign dvs_in = divisor;
        end
        else begin : g_next
            assign dvd_in = dvd_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign dvs_in = dvs_reg[s-1];
        end

        assign trial = {rem_in, dvd_in[QW-1]};
        assign diff  = trial - {1'b0, dvs_in};
        assign ge    = trial >= {1'b0, dvs_in};

        always_ff @(posedge clk)
        begin
            dvd_reg[s] <= {dvd_in[QW-2:0], 1'b0};
            quo_reg[s] <= {quo_in[QW-2:0], ge};
            rem_reg[s] <= ge ? diff[DIR_W-1:0] : trial[DIR_W-1:0];
            dvs_reg[s] <= dvs_in;
        end
    end

    assign quotient = quo_reg[QW-1];

endmodule

[sv/rbfh_face.sv]
module rbfh_face #(
    parameter int FRAC_BITS = rbfh_pkg::FRAC_BITS_DEF,
    parameter int AXIS      = 0,
    parameter bit USE_MAX   = 1'b1
) (
    input  logic            clk,
    input  rbfh_pkg::item_t item_in,
    input  rbfh_pkg::item_t item_dly,
    output logic            hit
);
    import rbfh_pkg::*;

    localparam int QW = MAG_W + FRAC_BITS;
    localparam int NW = COORD_W + 1;
    localparam int PW = MAG_W + 2;
    localparam int PH_W = MAG_W + DIR_W;
    localparam int U = (AXIS == 0) ? 1 : 0;
    localparam int V = (AXIS == 2) ? 1 : 2;

    logic signed [COORD_W-1:0] plane, o_a, d_a, lo_a, hi_a;
    logic signed [NW-1:0]      num;
    logic [MAG_W-1:0]          num_mag;
    logic [DIR_W-1:0]          dir_mag;

    logic [QW-1:0]    dvd_reg;
    logic [DIR_W-1:0] dvs_reg;
    logic [QW-1:0]    tmag;
    logic             tneg_reg [QW+1];
    logic             ok_reg   [QW+1];
    logic             ok_m_reg, ok_a_reg, ok_c_reg;
    logic             in_c_reg [2];
    logic             hit_reg;

    assign o_a   = item_in.o[AXIS];
    assign d_a   = item_in.d[AXIS];
    assign lo_a  = item_in.lo[AXIS];
    assign hi_a  = item_in.hi[AXIS];
    assign plane = USE_MAX ? hi_a : lo_a;

    assign num     = NW'(plane) - NW'(o_a);
    assign num_mag = num[NW-1] ? MAG_W'(-num) : MAG_W'(num);
    assign dir_mag = d_a[COORD_W-1] ? DIR_W'(-d_a) : DIR_W'(d_a);

    // The face coordinate is the plane itself, so it lies inside exactly when the
    // box is not inverted on this axis.
    always_ff @(posedge clk)
    begin
        dvd_reg     <= {num_mag, {FRAC_BITS{1'b0}}};
        dvs_reg     <= dir_mag;
        tneg_reg[0] <= num[NW-1] ^ d_a[COORD_W-1];
        ok_reg[0]   <= (d_a != '0) && (lo_a <= hi_a);
    end

    for (genvar s = 1; s <= QW; s++) begin : g_flag
        always_ff @(posedge clk)
        begin
            tneg_reg[s] <= tneg_reg[s-1];
            ok_reg[s]   <= ok_reg[s-1];
        end
    end

    rbfh_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .dividend (dvd_reg),
        .divisor  (dvs_reg),
        .quotient (tmag)
    );

    always_ff @(posedge clk)
    begin
        ok_m_reg <= ok_reg[QW];
        ok_a_reg <= ok_m_reg;
        ok_c_reg <= ok_a_reg;
    end

    for (genvar j = 0; j < 2; j++) begin : g_axis
        localparam int AX = (j == 0) ? U : V;

        logic signed [COORD_W-1:0] o_k, d_k;
        logic [DIR_W-1:0]          dm;
        logic [PH_W-1:0]           ph_reg;
        logic [FRAC_BITS+DIR_W-1:0] pl_reg;
        logic                      neg_m_reg, neg_a_reg;
        logic signed [COORD_W-1:0] o_m_reg, lo_m_reg, hi_m_reg;
        logic signed [COORD_W-1:0] o_a_reg, lo_a_reg, hi_a_reg;
        logic [PH_W:0]             q;
        logic [MAG_W-1:0]          q_reg;
        logic                      big_reg;
        logic signed [PW-1:0]      qs, p;

        assign o_k = item_dly.o[AX];
        assign d_k = item_dly.d[AX];
        assign dm  = d_k[COORD_W-1] ? DIR_W'(-d_k) : DIR_W'(d_k);

        // Split |t| into integer and fraction parts to keep each multiplier narrow.
        always_ff @(posedge clk)
        begin
            ph_reg    <= tmag[QW-1:FRAC_BITS] * dm;
            pl_reg    <= tmag[FRAC_BITS-1:0] * dm;
            neg_m_reg <= tneg_reg[QW] ^ d_k[COORD_W-1];
            o_m_reg   <= o_k;
            lo_m_reg  <= item_dly.lo[AX];
            hi_m_reg  <= item_dly.hi[AX];
        end

        assign q = (PH_W+1)'(ph_reg) + (PH_W+1)'(pl_reg[FRAC_BITS+DIR_W-1:FRAC_BITS]);

        // An offset of 2^33 or more puts the point outside any box.
        always_ff @(posedge clk)
        begin
            q_reg     <= q[MAG_W-1:0];
            big_reg   <= |q[PH_W:MAG_W];
            neg_a_reg <= neg_m_reg;
            o_a_reg   <= o_m_reg;
            lo_a_reg  <= lo_m_reg;
            hi_a_reg  <= hi_m_reg;
        end

        assign qs = signed'({2'b00, q_reg});
        assign p  = neg_a_reg ? (PW'(o_a_reg) - qs) : (PW'(o_a_reg) + qs);

        always_ff @(posedge clk)
        begin
            in_c_reg[j] <= !big_reg && (p >= PW'(lo_a_reg)) && (p <= PW'(hi_a_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= ok_c_reg && in_c_reg[0] && in_c_reg[1];
    end

    assign hit = hit_reg;

endmodule

[sv/ray_box_face_hit_test.sv]
// The result strobe is timed by a valid shift register matched to the face pipelines
// and their bit-per-stage dividers.
// Throughput: one request per cycle; busy is always low.
// Results cannot be stalled by the receiver and appear for one cycle with done.
// Reset (rst_n low, asynchronous) clears all valid bits; requests in flight are
// dropped.
module ray_box_face_hit_test #(
    parameter int FRAC_BITS = rbfh_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [31:0]           origin_x,
    input  logic signed [31:0]           origin_y,
    input  logic signed [31:0]           origin_z,
    input  logic signed [31:0]           dir_x,
    input  logic signed [31:0]           dir_y,
    input  logic signed [31:0]           dir_z,
    input  logic signed [31:0]           box_min_x,
    input  logic signed [31:0]           box_min_y,
    input  logic signed [31:0]           box_min_z,
    input  logic signed [31:0]           box_max_x,
    input  logic signed [31:0]           box_max_y,
    input  logic signed [31:0]           box_max_z,
    output logic                         done,
    output logic                         hit,
    output logic [rbfh_pkg::FACE_W-1:0]  hit_face
);
    import rbfh_pkg::*;

    localparam int QW  = MAG_W + FRAC_BITS;
    localparam int DLY = QW + 1;
    localparam int LAT = QW + 6;

    item_t             item_reg [DLY+1];
    logic [LAT:0]      vld_reg;
    logic [NUM_FACES-1:0] face_hit;
    logic [FACE_W-1:0] face_next;
    logic              hit_reg;
    logic [FACE_W-1:0] face_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg[0].o  <= {origin_z, origin_y, origin_x};
            item_reg[0].d  <= {dir_z, dir_y, dir_x};
            item_reg[0].lo <= {box_min_z, box_min_y, box_min_x};
            item_reg[0].hi <= {box_max_z, box_max_y, box_max_x};
        end
    end

    for (genvar j = 1; j <= DLY; j++) begin : g_dly
        always_ff @(posedge clk)
        begin
            item_reg[j] <= item_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-1:0], start && !busy};
        end
    end

    for (genvar f = 0; f < NUM_FACES; f++) begin : g_face
        rbfh_face #(
            .FRAC_BITS (FRAC_BITS),
            .AXIS      (face_axis(f)),
            .USE_MAX   (f < 3)
        ) u_face (
            .clk      (clk),
            .item_in  (item_reg[0]),
            .item_dly (item_reg[DLY]),
            .hit      (face_hit[f])
        );
    end

    always_comb
    begin
        if (face_hit[0])      face_next = FACE_PZ;
        else if (face_hit[1]) face_next = FACE_PY;
        else if (face_hit[2]) face_next = FACE_PX;
        else if (face_hit[3]) face_next = FACE_NZ;
        else if (face_hit[4]) face_next = FACE_NY;
        else if (face_hit[5]) face_next = FACE_NX;
        else                  face_next = FACE_NONE;
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= |face_hit;
        face_reg <= face_next;
    end

    assign done     = vld_reg[LAT];
    assign hit      = hit_reg;
    assign hit_face = face_reg;

endmodule

[sv/rbfh_checker.sv]
module rbfh_checker #(
    parameter int FRAC_BITS = rbfh_pkg::FRAC_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic                        hit,
    input logic [rbfh_pkg::FACE_W-1:0] hit_face
);
    import rbfh_pkg::*;

    localparam int LAT = MAG_W + FRAC_BITS + 6;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised on a fully pipelined block");

    a_hit_matches_face: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit == (hit_face != FACE_NONE)))
        else $error("hit flag disagrees with face code");

    a_face_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hit_face <= FACE_NONE))
        else $error("illegal face code");

    // The strobe is seen at the edge that follows the last pipeline stage.
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(LAT+1) done)
        else $error("result missing at fixed latency");

endmodule

bind ray_box_face_hit_test rbfh_checker #(.FRAC_BITS(FRAC_BITS)) u_rbfh_checker (.*);

[bench/ray_box_face_hit_test_tb.sv]
`timescale 1ns / 100ps

module ray_box_face_hit_test_tb;
    import rbfh_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = FB + 39;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct {
        logic hit;
        logic [FACE_W-1:0] face;
    } verdict_t;

    class hit_scoreboard;
        verdict_t pending[$];
        int errors;
        int checked;
        int hits;

        // Tests one face; wide arithmetic throughout so nothing wraps.
        function automatic bit face_inside(coord_t o[3], coord_t d[3], coord_t lo[3],
                                           coord_t hi[3], int axis, longint plane);
            longint num, p;
            logic [127:0] tmag, prod, q;
            logic [63:0] dm;
            bit tneg, neg;
            if (d[axis] == 0)
                return 0;
            num = plane - longint'(o[axis]);
            tneg = (num < 0) != (d[axis] < 0);
            dm = (d[axis] < 0) ? -longint'(d[axis]) : longint'(d[axis]);
            tmag = ((num < 0 ? 128'(-num) : 128'(num)) << FB) / dm;
            for (int k = 0; k < 3; k++) begin
                if (k == axis)
                    p = plane;
                else begin
                    dm = (d[k] < 0) ? -longint'(d[k]) : longint'(d[k]);
                    neg = tneg != (d[k] < 0);
                    prod = tmag * dm;
                    q = prod >> FB;
                    // Offsets past the cap lie outside any box anyway.
                    if (prod > (128'd1 << 62) || q > (128'd1 << 34))
                        q = 128'd1 << 34;
                    p = longint'(o[k]) + (neg ? -longint'(q[63:0]) : longint'(q[63:0]));
                end
                if (p < longint'(lo[k]) || p > longint'(hi[k]))
                    return 0;
            end
            return 1;
        endfunction

        function void note_request(item_t it);
            coord_t o[3], d[3], lo[3], hi[3];
            verdict_t v;
            int a;
            for (int i = 0; i < 3; i++) begin
                o[i] = it.o[i]; d[i] = it.d[i]; lo[i] = it.lo[i]; hi[i] = it.hi[i];
            end
            v.hit = 0;
            v.face = FACE_NONE;
            for (int f = 0; f < NUM_FACES; f++) begin
                a = (f == 0 || f == 3) ? 2 : (f == 1 || f == 4) ? 1 : 0;
                if (face_inside(o, d, lo, hi, a, (f < 3) ? longint'(hi[a]) : longint'(lo[a])))
                begin
                    v.hit = 1;
                    v.face = f[FACE_W-1:0];
                    break;
                end
            end
            pending.push_back(v);
        endfunction

        function void check_result(logic h, logic [FACE_W-1:0] f);
            verdict_t v;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result hit=%0d face=%0d", $time, h, f);
                errors++;
                return;
            end
            v = pending.pop_front();
            if (h === 1'b1)
                hits++;
            if (h !== v.hit) begin
                $display("%0t: hit expected %0d actual %0d", $time, v.hit, h);
                errors++;
            end
            if (f !== v.face) begin
                $display("%0t: hit_face expected %0d actual %0d", $time, v.face, f);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy, done, hit;
    logic [FACE_W-1:0] hit_face;
    item_t req = '0;
    hit_scoreboard board = new();
    longint cycles = 0;
    int sent = 0;

    always #6 clk = ~clk;

    ray_box_face_hit_test dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .origin_x(req.o[0]), .origin_y(req.o[1]), .origin_z(req.o[2]),
        .dir_x(req.d[0]), .dir_y(req.d[1]), .dir_z(req.d[2]),
        .box_min_x(req.lo[0]), .box_min_y(req.lo[1]), .box_min_z(req.lo[2]),
        .box_max_x(req.hi[0]), .box_max_y(req.hi[1]), .box_max_z(req.hi[2]),
        .done(done), .hit(hit), .hit_face(hit_face)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && start && !busy) begin
            board.note_request(req);
            sent <= sent + 1;
        end
        if (rst_n && done)
            board.check_result(hit, hit_face);
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL ray_box_face_hit_test");
            $finish;
        end
    end

    task automatic send(item_t it);
        @(negedge clk);
        req <= it;
        start <= 1;
        do @(posedge clk); while (busy);
    endtask

    task automatic pause(int n);
        @(negedge clk);
        start <= 0;
        repeat (n) @(negedge clk);
    endtask

    function automatic coord_t rnd_coord();
        case ($urandom_range(0, 5))
            0: return coord_t'($urandom);
            1: return 32'sh7fffffff - $urandom_range(0, 3);
            2: return 32'sh80000000 + $urandom_range(0, 3);
            3: return 0;
            default: return coord_t'(int'($urandom_range(0, 40 << FB)) - (20 << FB));
        endcase
    endfunction

    // Ray aimed from a random origin toward a random point of a small box.
    function automatic item_t aimed_ray();
        item_t it;
        coord_t tgt;
        for (int k = 0; k < 3; k++) begin
            it.lo[k] = coord_t'(int'($urandom_range(0, 20 << FB)) - (10 << FB));
            it.hi[k] = it.lo[k] + coord_t'($urandom_range(0, 8 << FB));
            tgt = it.lo[k] + coord_t'($urandom_range(0, it.hi[k] - it.lo[k]));
            it.o[k] = coord_t'(int'($urandom_range(0, 60 << FB)) - (30 << FB));
            it.d[k] = ($urandom_range(0, 7) == 0) ? 0 : tgt - it.o[k];
        end
        return it;
    endfunction

    function automatic item_t noise_ray();
        item_t it;
        for (int k = 0; k < 3; k++) begin
            it.o[k] = rnd_coord(); it.d[k] = rnd_coord();
            it.lo[k] = rnd_coord(); it.hi[k] = rnd_coord();
        end
        return it;
    endfunction

    function automatic item_t unit_box(coord_t ox, coord_t oy, coord_t oz,
                                       coord_t dx, coord_t dy, coord_t dz);
        item_t it;
        it.o = {oz, oy, ox};
        it.d = {dz, dy, dx};
        for (int k = 0; k < 3; k++) begin
            it.lo[k] = -(1 <<< FB);
            it.hi[k] = 1 <<< FB;
        end
        return it;
    endfunction

    initial begin
        item_t it;
        int burst;
        localparam coord_t ONE = 1 <<< FB;
        localparam coord_t FAR = 5 <<< FB;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // Each face in turn, from both sides, and through the origin.
        send(unit_box(0, 0, FAR, 0, 0, -ONE));
        send(unit_box(0, FAR, 0, 0, -ONE, 0));
        send(unit_box(FAR, 0, 0, -ONE, 0, 0));
        send(unit_box(0, 0, -FAR, 0, 0, ONE));
        send(unit_box(0, -FAR, 0, 0, ONE, 0));
        send(unit_box(-FAR, 0, 0, ONE, 0, 0));
        send(unit_box(0, 0, FAR, 0, 0, ONE));       // hit behind the origin
        send(unit_box(0, 0, 0, 0, 0, 0));           // every face skipped
        send(unit_box(FAR, FAR, 0, 0, 0, ONE));     // miss
        send(unit_box(ONE, ONE, FAR, 0, 0, -ONE));  // corner, bounds inclusive
        send(unit_box(0, 0, FAR, ONE, ONE, -1));    // huge offsets
        it = unit_box(0, 0, FAR, 0, 0, -ONE);
        it.lo[0] = ONE; it.hi[0] = -ONE;            // inverted box
        send(it);
        for (int k = 0; k < 3; k++) begin
            it.o[k] = 32'sh7fffffff; it.d[k] = 32'sh80000000;
            it.lo[k] = 32'sh80000000; it.hi[k] = 32'sh7fffffff;
        end
        send(it);
        for (int k = 0; k < 3; k++) begin
            it.o[k] = 32'sh80000000; it.d[k] = 32'sh7fffffff;
            it.lo[k] = 32'sh7fffffff; it.hi[k] = 32'sh80000000;
        end
        send(it);
        send(unit_box(0, 0, FAR, 32'sh7fffffff, 32'sh80000000, 1));

        // Hold off until the pipeline has drained once.
        pause(0);
        while (board.pending.size() != 0) @(negedge clk);

        while (sent < 420) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst; i++)
                send(($urandom_range(0, 3) != 0) ? aimed_ray() : noise_ray());
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 70));
        end
        pause(0);

        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        $display("Sent %0d ray-box requests, %0d results checked, %0d of them hits.",
                 sent, board.checked, board.hits);
        if (board.errors == 0)
            $display("PASS ray_box_face_hit_test");
        else
            $display("FAIL ray_box_face_hit_test");
        $finish;
    end
endmodule
